### sv/rtpg711_pkg.sv
`timescale 1ns / 1ps

package rtpg711_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned StatusW = 3;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_VERSION = 3'd2,
    ST_TYPE    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  localparam logic [1:0] RtpVersion = 2'd2;
  localparam logic [6:0] PtUlaw     = 7'd0;
  localparam logic [6:0] PtAlaw     = 7'd8;

endpackage

### sv/rtp_g711_payload_decoder_top.sv
`timescale 1ns / 1ps
// A result is registered and appears on the master side in the cycle after its input transfer.
// Throughput: one byte per cycle; the input is stalled only while a result is held
//   and the master side is not ready.
// Reset (rst_ni low, asynchronous): header tracking returns to the first byte of a
//   packet and the result register is emptied.
module rtp_g711_payload_decoder_top
  import rtpg711_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [ByteW-1:0]   s_tdata_i,   // [7:0] packet_byte
  input  logic               s_tlast_i,   // end_of_packet
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [SampleW-1:0] m_tdata_o,   // [15:0] pcm_sample
  output logic [StatusW-1:0] m_tuser_o,   // [2:0] status
  output logic               m_tlast_o    // last_sample
);

  localparam int unsigned PosW = $clog2(HEADER_BYTES + 1);
  localparam logic [PosW-1:0] HdrLen = PosW'(HEADER_BYTES);

  // header state
  logic [PosW-1:0] pos_q, pos_d;
  logic            ver_q, ver_d;
  logic            type_q, type_d;
  logic            alaw_q, alaw_d;

  // result register
  logic                      valid_q, valid_d;
  logic signed [SampleW-1:0] sample_q, sample_d;
  status_e                   status_q, status_d;
  logic                      last_q, last_d;

  logic in_xfer;
  logic in_header;
  logic ver_n, type_n, alaw_n;
  logic [PosW-1:0] pos_inc;
  logic signed [SampleW-1:0] alaw_pcm, ulaw_pcm;

  assign s_tready_o = !valid_q || m_tready_i;
  assign in_xfer    = s_tvalid_i && s_tready_o;
  assign in_header  = pos_q < HdrLen;
  assign pos_inc    = pos_q + PosW'(1);

  // A-law: sign set after the 0x55 XOR means positive
  always_comb begin
    logic [7:0]  a;
    logic [14:0] mag;
    a   = s_tdata_i ^ 8'h55;
    mag = {7'd0, a[3:0], 4'd0};
    if (a[6:4] == 3'd0) begin
      mag = mag + 15'h008;
    end else begin
      mag = (mag + 15'h108) << (a[6:4] - 3'd1);
    end
    alaw_pcm = a[7] ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
  end

  // mu-law with the 0x84 bias removed
  always_comb begin
    logic [7:0]  u;
    logic [14:0] mag;
    logic [14:0] v;
    u   = ~s_tdata_i;
    mag = ({8'd0, u[3:0], 3'd0} + 15'h084) << u[6:4];
    v   = mag - 15'h084;
    ulaw_pcm = u[7] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  end

  // header fields as updated by the current byte
  always_comb begin
    ver_n  = ver_q;
    type_n = type_q;
    alaw_n = alaw_q;
    if (pos_q == PosW'(0)) begin
      ver_n = s_tdata_i[7:6] == RtpVersion;
    end else if (pos_q == PosW'(1)) begin
      type_n = (s_tdata_i[6:0] == PtUlaw) || (s_tdata_i[6:0] == PtAlaw);
      alaw_n = s_tdata_i[6:0] == PtAlaw;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    ver_d    = ver_q;
    type_d   = type_q;
    alaw_d   = alaw_q;
    valid_d  = valid_q && !m_tready_i;
    sample_d = sample_q;
    status_d = status_q;
    last_d   = last_q;
    if (in_xfer) begin
      sample_d = '0;
      last_d   = 1'b1;
      if (in_header) begin
        pos_d  = pos_inc;
        ver_d  = ver_n;
        type_d = type_n;
        alaw_d = alaw_n;
        valid_d = s_tlast_i;
        priority if (pos_inc < HdrLen) begin
          status_d = ST_SHORT;
        end else if (!ver_n) begin
          status_d = ST_VERSION;
        end else if (!type_n) begin
          status_d = ST_TYPE;
        end else begin
          status_d = ST_EMPTY;
        end
      end else if (ver_q && type_q) begin
        valid_d  = 1'b1;
        sample_d = alaw_q ? alaw_pcm : ulaw_pcm;
        status_d = ST_OK;
        last_d   = s_tlast_i;
      end else begin
        valid_d  = s_tlast_i;
        status_d = ver_q ? ST_TYPE : ST_VERSION;
      end
      if (s_tlast_i) begin
        pos_d  = '0;
        ver_d  = 1'b0;
        type_d = 1'b0;
        alaw_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ver_q   <= 1'b0;
      type_q  <= 1'b0;
      alaw_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      ver_q   <= ver_d;
      type_q  <= type_d;
      alaw_q  <= alaw_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = sample_q;
  assign m_tuser_o  = status_q;
  assign m_tlast_o  = last_q;

endmodule

### sv/rtpg711_checker.sv
`timescale 1ns / 1ps
module rtpg711_checker
  import rtpg711_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_tvalid_i,
  input logic               s_tready_o,
  input logic               s_tlast_i,
  input logic               m_tvalid_o,
  input logic               m_tready_i,
  input logic [SampleW-1:0] m_tdata_o,
  input logic [StatusW-1:0] m_tuser_o,
  input logic               m_tlast_o
);

  // error results close the packet and carry no sample
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o != ST_OK) |-> (m_tlast_o && m_tdata_o == '0))
    else $error("error result without tlast or with nonzero sample");

  // the last byte of a packet always produces a closing result
  a_eop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && s_tlast_i) |=> (m_tvalid_o && m_tlast_o))
    else $error("end of packet gave no final result");

  // input only backs up when a result is held
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> (m_tvalid_o && !m_tready_i))
    else $error("input stalled without output backpressure");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tready_i) |=> (m_tvalid_o && $stable(m_tdata_o) &&
      $stable(m_tuser_o) && $stable(m_tlast_o)))
    else $error("stalled result changed");

endmodule

bind rtp_g711_payload_decoder_top rtpg711_checker u_rtpg711_checker (.*);
